// ----- src/mlh_pkg.sv -----
// Shared types and constants for the monotone line hull block.
// No dependencies; imported by every module of the block.
`default_nettype none

package mlh_pkg;

	// Input op codes
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// Breakpoint used for an equal-slope tie and for the last line
	localparam logic signed [63:0] HULL_INF = 64'sd1000000000000000000;

	// Divider: one quotient bit per cycle over a 49-bit magnitude
	localparam int DIV_STEPS = 49;
	localparam int DIV_CW    = 6;

	// Datapath commands
	localparam logic [4:0] CMD_NONE     = 5'd0;
	localparam logic [4:0] CMD_LOAD     = 5'd1;
	localparam logic [4:0] CMD_RD_HEAD  = 5'd2;
	localparam logic [4:0] CMD_RD_TAIL  = 5'd3;
	localparam logic [4:0] CMD_RD_IDX   = 5'd4;
	localparam logic [4:0] CMD_RD_BACK  = 5'd5;
	localparam logic [4:0] CMD_CROSS_F  = 5'd6;
	localparam logic [4:0] CMD_CROSS_B  = 5'd7;
	localparam logic [4:0] CMD_INC_IDX  = 5'd8;
	localparam logic [4:0] CMD_DEC_IDX  = 5'd9;
	localparam logic [4:0] CMD_T_INF    = 5'd10;
	localparam logic [4:0] CMD_WR_FRONT = 5'd11;
	localparam logic [4:0] CMD_WR_BP    = 5'd12;
	localparam logic [4:0] CMD_WR_BACK  = 5'd13;
	localparam logic [4:0] CMD_POP      = 5'd14;
	localparam logic [4:0] CMD_RD_BPQ   = 5'd15;
	localparam logic [4:0] CMD_RD_VAL   = 5'd16;
	localparam logic [4:0] CMD_MUL      = 5'd17;
	localparam logic [4:0] CMD_OUT_VAL  = 5'd18;
	localparam logic [4:0] CMD_OUT_ST   = 5'd19;

	typedef struct packed {
		logic [4:0] code;
		logic [1:0] st;
	} mlh_cmd_t;

	typedef struct packed {
		logic is_query;
		logic count_zero;
		logic count_one;
		logic idx_eq_count;
		logic idx_zero;
		logic slope_ge_rd;
		logic slope_gt_rd;
		logic t_ge_bp;
		logic bp_ge_t;
		logic q_pop;
		logic front_full;
		logic back_full;
		logic cross_done;
		logic out_busy;
	} mlh_stat_t;

endpackage

`default_nettype wire

// ----- src/monotone_line_hull_min_query.sv -----
// Top level of the monotone line hull: minimum-of-lines queries over a deque.
// Depends on mlh_pkg, mlh_ctrl, mlh_datapath (and mlh_cross below it).
//
// Usage:
//   Input channel in_valid/in_ready carries one word: op, slope, intercept,
//   query_point. op=0 adds the line slope*x+intercept, op=1 asks the minimum
//   of the kept lines at query_point.
//   Output channel out_valid/out_ready returns one word per input word:
//   min_value (zero for adds and errors) and status (ok, query on empty,
//   slope out of order, deque full).
//   cfg_we/cfg_wdata writes query_increasing (1 = query points rise).
//   A query pops stale lines one by one before it evaluates the survivor. An
//   add examines lines one by one, each examination being one breakpoint
//   division done one quotient bit per cycle (49 bits).
//   One word is worked at a time; the next one is taken once the current
//   result sits in the output register, so the receiver may hold it.
//   A stalled receiver stops the block only when a new result is ready.
//   Reset empties the deque and sets query_increasing to 1; the line
//   memories are not cleared, as only live entries are ever read.
`default_nettype none

module monotone_line_hull_min_query import mlh_pkg::*; #(
	parameter int HULL_DEPTH = 1024
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire                cfg_wdata,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire                op,
	input  wire signed [31:0]  slope,
	input  wire signed [47:0]  intercept,
	input  wire signed [31:0]  query_point,
	output logic               out_valid,
	input  wire                out_ready,
	output logic signed [63:0] min_value,
	output logic [1:0]         status
);

	mlh_cmd_t  cmd;
	mlh_stat_t stat;

	mlh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mlh_datapath #(
		.HULL_DEPTH (HULL_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.op          (op),
		.slope       (slope),
		.intercept   (intercept),
		.query_point (query_point),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.min_value   (min_value),
		.status      (status)
	);

endmodule

`default_nettype wire

// ----- src/mlh_cross.sv -----
// Breakpoint unit: floor((b1-b2)/(a2-a1)) by restoring division, or +/-INF on a tie.
// Depends on mlh_pkg.
`default_nettype none

module mlh_cross import mlh_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire signed [32:0]  a1,
	input  wire signed [48:0]  b1,
	input  wire signed [32:0]  a2,
	input  wire signed [48:0]  b2,
	output logic               done,
	output logic signed [63:0] t
);

	logic              busy_q, fix_q, done_q, neg_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [48:0]       num_q;
	logic [31:0]       rem_q, den_q;
	logic signed [63:0] t_q;

	logic signed [49:0] n_w;
	logic signed [33:0] d_w;
	logic [49:0]        mag_w;
	logic [32:0]        rem_sh;
	logic               ge;
	logic [32:0]        rem_nx;
	logic signed [63:0] q64;

	// operand prep
	always_comb begin
		n_w    = {b1[48], b1} - {b2[48], b2};
		d_w    = {a2[32], a2} - {a1[32], a1};
		mag_w  = n_w[49] ? 50'(-n_w) : n_w;
		rem_sh = {rem_q, num_q[48]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
		q64    = {15'd0, num_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (a1 == a2) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= DIV_CW'(DIV_STEPS - 1);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end else if (fix_q) begin
				fix_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			t_q   <= (b1 >= b2) ? HULL_INF : -HULL_INF;
			num_q <= mag_w[48:0];
			rem_q <= '0;
			den_q <= d_w[31:0];
			neg_q <= n_w[49];
		end else if (busy_q) begin
			num_q <= {num_q[47:0], ge};
			rem_q <= rem_nx[31:0];
		end else if (fix_q) begin
			// round toward minus infinity for a negative numerator
			t_q <= neg_q ? (-q64 - ((rem_q != '0) ? 64'sd1 : 64'sd0)) : q64;
		end
	end

	assign done = done_q;
	assign t    = t_q;

endmodule

`default_nettype wire

// ----- src/mlh_datapath.sv -----
// Datapath: line memories, deque pointers, breakpoint unit, query multiply, result word.
// Depends on mlh_pkg and mlh_cross.
`default_nettype none

module mlh_datapath import mlh_pkg::*; #(
	parameter int HULL_DEPTH = 1024
) (
	input  wire                clk,
	input  wire                arst_n,
	input  mlh_cmd_t           cmd,
	output mlh_stat_t          stat,
	input  wire                cfg_we,
	input  wire                cfg_wdata,
	input  wire                op,
	input  wire signed [31:0]  slope,
	input  wire signed [47:0]  intercept,
	input  wire signed [31:0]  query_point,
	output logic               out_valid,
	input  wire                out_ready,
	output logic signed [63:0] min_value,
	output logic [1:0]         status
);

	localparam int AW = $clog2(HULL_DEPTH);
	localparam int CW = $clog2(HULL_DEPTH + 1);

	// memories
	logic [31:0] mem_slope [HULL_DEPTH];
	logic [47:0] mem_icpt  [HULL_DEPTH];
	logic [63:0] mem_bp    [HULL_DEPTH];

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q, idx_q;
	logic          qinc_q, out_valid_q;
	logic          op_q;
	logic signed [31:0] slope_q, qx_q, rd_slope_q;
	logic signed [47:0] icpt_q, rd_icpt_q;
	logic signed [63:0] rd_bp_q, t_q, prod_q, min_q;
	logic [1:0]         status_q;

	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] p);
		logic [CW:0] s;
		s = {{(CW + 1 - AW){1'b0}}, h} + {1'b0, p};
		if (s >= (CW + 1)'(HULL_DEPTH))
			s = s - (CW + 1)'(HULL_DEPTH);
		return s[AW-1:0];
	endfunction

	// negated lines for the breakpoint unit
	logic signed [32:0] na_new, na_rd;
	logic signed [48:0] nb_new, nb_rd;
	logic signed [32:0] x_a1, x_a2;
	logic signed [48:0] x_b1, x_b2;
	logic               x_start, x_done;
	logic signed [63:0] x_t;

	always_comb begin
		na_new = -{slope_q[31], slope_q};
		na_rd  = -{rd_slope_q[31], rd_slope_q};
		nb_new = -{icpt_q[47], icpt_q};
		nb_rd  = -{rd_icpt_q[47], rd_icpt_q};
		x_start = (cmd.code == CMD_CROSS_F) || (cmd.code == CMD_CROSS_B);
		if (cmd.code == CMD_CROSS_B) begin
			x_a1 = na_rd;  x_b1 = nb_rd;  x_a2 = na_new; x_b2 = nb_new;
		end else begin
			x_a1 = na_new; x_b1 = nb_new; x_a2 = na_rd;  x_b2 = nb_rd;
		end
	end

	mlh_cross u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (x_start),
		.a1     (x_a1),
		.b1     (x_b1),
		.a2     (x_a2),
		.b2     (x_b2),
		.done   (x_done),
		.t      (x_t)
	);

	// memory addressing
	logic [CW-1:0] cnt_m1, cnt_m2, idx_m1, idx_p1;
	logic [CW-1:0] line_pos, bp_pos;
	logic [AW-1:0] lra, bra, lwa, bwa, new_head;
	logic          rd_en, lwe, bwe;
	logic [63:0]   bwd;

	always_comb begin
		cnt_m1 = count_q - CW'(1);
		cnt_m2 = (count_q >= CW'(2)) ? count_q - CW'(2) : '0;
		idx_m1 = (idx_q == '0) ? '0 : idx_q - CW'(1);
		idx_p1 = idx_q + CW'(1);
		line_pos = '0;
		bp_pos   = '0;
		rd_en    = 1'b0;
		unique case (cmd.code)
			CMD_RD_HEAD: begin rd_en = 1'b1; end
			CMD_RD_TAIL: begin rd_en = 1'b1; line_pos = cnt_m1; bp_pos = cnt_m1; end
			CMD_RD_IDX:  begin rd_en = 1'b1; line_pos = idx_q; bp_pos = idx_q; end
			CMD_RD_BACK: begin rd_en = 1'b1; line_pos = idx_q; bp_pos = idx_m1; end
			CMD_RD_BPQ: begin
				rd_en  = 1'b1;
				bp_pos = qinc_q ? '0 : cnt_m2;
			end
			CMD_RD_VAL: begin
				rd_en    = 1'b1;
				line_pos = qinc_q ? '0 : cnt_m1;
			end
			default: ;
		endcase
		lra = slot_of(head_q, line_pos);
		bra = slot_of(head_q, bp_pos);

		// new head for a front insert
		if (idx_q == '0)
			new_head = (head_q == '0) ? AW'(HULL_DEPTH - 1) : head_q - AW'(1);
		else
			new_head = slot_of(head_q, idx_m1);

		lwe = 1'b0;
		bwe = 1'b0;
		lwa = new_head;
		bwa = new_head;
		bwd = t_q;
		unique case (cmd.code)
			CMD_WR_FRONT: begin lwe = 1'b1; bwe = 1'b1; end
			CMD_WR_BP:    begin bwe = 1'b1; bwa = slot_of(head_q, idx_q); end
			CMD_WR_BACK: begin
				lwe = 1'b1;
				bwe = 1'b1;
				lwa = slot_of(head_q, idx_p1);
				bwa = lwa;
				bwd = HULL_INF;
			end
			default: ;
		endcase
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (lwe) begin
			mem_slope[lwa] <= slope_q;
			mem_icpt[lwa]  <= icpt_q;
		end
		if (bwe)
			mem_bp[bwa] <= bwd;
		if (rd_en) begin
			rd_slope_q <= mem_slope[lra];
			rd_icpt_q  <= mem_icpt[lra];
			rd_bp_q    <= mem_bp[bra];
		end
	end

	logic out_load;
	assign out_load = (cmd.code == CMD_WR_FRONT) || (cmd.code == CMD_WR_BACK) ||
	                  (cmd.code == CMD_OUT_VAL) || (cmd.code == CMD_OUT_ST);

	// deque pointers, order register, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			qinc_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				qinc_q <= cfg_wdata;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (cmd.code)
				CMD_LOAD:    idx_q <= '0;
				CMD_RD_TAIL: idx_q <= cnt_m1;
				CMD_INC_IDX: idx_q <= idx_p1;
				CMD_DEC_IDX: idx_q <= idx_q - CW'(1);
				CMD_WR_FRONT: begin
					head_q  <= new_head;
					count_q <= count_q - idx_q + CW'(1);
				end
				CMD_WR_BACK: count_q <= idx_q + CW'(2);
				CMD_POP: begin
					if (qinc_q)
						head_q <= slot_of(head_q, CW'(1));
					count_q <= cnt_m1;
				end
				default: ;
			endcase
		end
	end

	logic signed [63:0] prod_w, qx64, icpt64;
	assign prod_w = rd_slope_q * qx_q;
	assign qx64   = {{32{qx_q[31]}}, qx_q};
	assign icpt64 = {{16{rd_icpt_q[47]}}, rd_icpt_q};

	// item, breakpoint, product and result words
	always_ff @(posedge clk) begin
		if (cmd.code == CMD_LOAD) begin
			op_q    <= op;
			slope_q <= slope;
			icpt_q  <= intercept;
			qx_q    <= query_point;
		end
		if (x_done)
			t_q <= x_t;
		else if (cmd.code == CMD_T_INF)
			t_q <= HULL_INF;
		if (cmd.code == CMD_MUL)
			prod_q <= prod_w;
		if (cmd.code == CMD_OUT_VAL) begin
			min_q    <= prod_q + icpt64;
			status_q <= ST_OK;
		end else if (cmd.code == CMD_OUT_ST) begin
			min_q    <= '0;
			status_q <= cmd.st;
		end else if (out_load) begin
			min_q    <= '0;
			status_q <= ST_OK;
		end
	end

	// status to the controller
	always_comb begin
		stat.is_query     = (op_q == OP_QUERY);
		stat.count_zero   = (count_q == '0);
		stat.count_one    = (count_q == CW'(1));
		stat.idx_eq_count = (idx_q == count_q);
		stat.idx_zero     = (idx_q == '0);
		stat.slope_ge_rd  = (slope_q >= rd_slope_q);
		stat.slope_gt_rd  = (slope_q > rd_slope_q);
		stat.t_ge_bp      = (t_q >= rd_bp_q);
		stat.bp_ge_t      = (rd_bp_q >= t_q);
		stat.q_pop        = qinc_q ? (rd_bp_q < qx64) : (rd_bp_q >= qx64);
		stat.front_full   = ({1'b0, count_q} - {1'b0, idx_q} + (CW + 1)'(1)) >
		                    (CW + 1)'(HULL_DEPTH);
		stat.back_full    = ({1'b0, idx_q} + (CW + 1)'(2)) > (CW + 1)'(HULL_DEPTH);
		stat.cross_done   = x_done;
		stat.out_busy     = out_valid_q && !out_ready;
	end

	assign out_valid = out_valid_q;
	assign min_value = min_q;
	assign status    = status_q;

endmodule

`default_nettype wire

// ----- src/mlh_ctrl.sv -----
// Controller state machine: sequences adds, pops and queries over the datapath.
// Depends on mlh_pkg.
`default_nettype none

module mlh_ctrl import mlh_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	output logic      in_ready,
	input  mlh_stat_t stat,
	output mlh_cmd_t  cmd
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DISP   = 5'd1;
	localparam logic [4:0] S_A1     = 5'd2;
	localparam logic [4:0] S_A2     = 5'd3;
	localparam logic [4:0] S_F_RD   = 5'd4;
	localparam logic [4:0] S_F_CX   = 5'd5;
	localparam logic [4:0] S_F_W    = 5'd6;
	localparam logic [4:0] S_F_CMP  = 5'd7;
	localparam logic [4:0] S_F_FIN  = 5'd8;
	localparam logic [4:0] S_B_RD   = 5'd9;
	localparam logic [4:0] S_B_CX   = 5'd10;
	localparam logic [4:0] S_B_W    = 5'd11;
	localparam logic [4:0] S_B_CMP  = 5'd12;
	localparam logic [4:0] S_B_FIN  = 5'd13;
	localparam logic [4:0] S_B_FIN2 = 5'd14;
	localparam logic [4:0] S_Q_RD   = 5'd15;
	localparam logic [4:0] S_Q_CHK  = 5'd16;
	localparam logic [4:0] S_Q_MUL  = 5'd17;
	localparam logic [4:0] S_Q_OUT  = 5'd18;
	localparam logic [4:0] S_ST     = 5'd19;

	logic [4:0] state_q, state_d;
	logic [1:0] st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

	// next state and command
	always_comb begin
		state_d  = state_q;
		st_d     = st_q;
		cmd.code = CMD_NONE;
		cmd.st   = st_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.code = CMD_LOAD;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				if (stat.is_query) begin
					if (stat.count_zero) begin
						st_d    = ST_EMPTY;
						state_d = S_ST;
					end else begin
						state_d = S_Q_RD;
					end
				end else if (stat.count_zero) begin
					state_d = S_F_RD;
				end else begin
					cmd.code = CMD_RD_HEAD;
					state_d  = S_A1;
				end
			end
			S_A1: begin
				if (stat.slope_ge_rd) begin
					state_d = S_F_CX;
				end else begin
					cmd.code = CMD_RD_TAIL;
					state_d  = S_A2;
				end
			end
			S_A2: begin
				if (stat.slope_gt_rd) begin
					st_d    = ST_ORDER;
					state_d = S_ST;
				end else begin
					state_d = S_B_RD;
				end
			end
			// front insert: pop while the new line covers the front line
			S_F_RD: begin
				if (stat.idx_eq_count) begin
					cmd.code = CMD_T_INF;
					state_d  = S_F_FIN;
				end else begin
					cmd.code = CMD_RD_IDX;
					state_d  = S_F_CX;
				end
			end
			S_F_CX: begin
				cmd.code = CMD_CROSS_F;
				state_d  = S_F_W;
			end
			S_F_W: if (stat.cross_done) state_d = S_F_CMP;
			S_F_CMP: begin
				if (stat.t_ge_bp) begin
					cmd.code = CMD_INC_IDX;
					state_d  = S_F_RD;
				end else begin
					state_d = S_F_FIN;
				end
			end
			S_F_FIN: begin
				if (stat.front_full) begin
					st_d    = ST_FULL;
					state_d = S_ST;
				end else if (!stat.out_busy) begin
					cmd.code = CMD_WR_FRONT;
					state_d  = S_IDLE;
				end
			end
			// back insert: drop back lines whose range closes
			S_B_RD: begin
				cmd.code = CMD_RD_BACK;
				state_d  = S_B_CX;
			end
			S_B_CX: begin
				cmd.code = CMD_CROSS_B;
				state_d  = S_B_W;
			end
			S_B_W: if (stat.cross_done) state_d = S_B_CMP;
			S_B_CMP: begin
				if (!stat.idx_zero && stat.bp_ge_t) begin
					cmd.code = CMD_DEC_IDX;
					state_d  = S_B_RD;
				end else begin
					state_d = S_B_FIN;
				end
			end
			S_B_FIN: begin
				if (stat.back_full) begin
					st_d    = ST_FULL;
					state_d = S_ST;
				end else begin
					cmd.code = CMD_WR_BP;
					state_d  = S_B_FIN2;
				end
			end
			S_B_FIN2: begin
				if (!stat.out_busy) begin
					cmd.code = CMD_WR_BACK;
					state_d  = S_IDLE;
				end
			end
			// query: pop stale lines, then evaluate the survivor
			S_Q_RD: begin
				if (stat.count_one) begin
					cmd.code = CMD_RD_VAL;
					state_d  = S_Q_MUL;
				end else begin
					cmd.code = CMD_RD_BPQ;
					state_d  = S_Q_CHK;
				end
			end
			S_Q_CHK: begin
				if (stat.q_pop) begin
					cmd.code = CMD_POP;
					state_d  = S_Q_RD;
				end else begin
					cmd.code = CMD_RD_VAL;
					state_d  = S_Q_MUL;
				end
			end
			S_Q_MUL: begin
				cmd.code = CMD_MUL;
				state_d  = S_Q_OUT;
			end
			S_Q_OUT: begin
				if (!stat.out_busy) begin
					cmd.code = CMD_OUT_VAL;
					state_d  = S_IDLE;
				end
			end
			S_ST: begin
				if (!stat.out_busy) begin
					cmd.code = CMD_OUT_ST;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ----- src/mlh_checker.sv -----
// Port-level checks for the monotone line hull, bound to the top level.
// Depends on mlh_pkg and monotone_line_hull_min_query.
`default_nettype none

module mlh_checker import mlh_pkg::*; (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [63:0] min_value,
	input wire [1:0]  status
);

	// a held result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(min_value) && $stable(status))
		else $error("result word changed while stalled");

	// error results carry a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (min_value == 64'd0))
		else $error("error result with nonzero value");

	// one word at a time: busy right after taking a word
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in work");

endmodule

bind monotone_line_hull_min_query mlh_checker u_mlh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.min_value (min_value),
	.status    (status)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for monotone_line_hull_min_query (min-of-lines hull).
// Depends on mlh_pkg and the block's RTL; a scoreboard class predicts each result word.
`timescale 1ns / 100ps

import mlh_pkg::*;

// Hull predictor and expected-word store
class hull_scoreboard;
	localparam int DEPTH = 1024;
	localparam longint INF = 64'sd1000000000000000000;

	int          slopes[DEPTH];
	longint      icpts[DEPTH];
	longint      bps[DEPTH];
	int unsigned head;
	int unsigned count;
	bit          q_rising;
	longint      exp_value[$];
	logic [1:0]  exp_status[$];
	int          errors;

	function new();
		head = 0;
		count = 0;
		q_rising = 1'b1;
		errors = 0;
	endfunction

	function int unsigned slot(int unsigned pos);
		return (head + pos) % DEPTH;
	endfunction

	function int pending();
		return exp_status.size();
	endfunction

	function int front_slope();
		return slopes[slot(0)];
	endfunction

	function int back_slope();
		return slopes[slot(count - 1)];
	endfunction

	function longint div_down(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && ((n < 0) != (d < 0)))
			q -= 1;
		return q;
	endfunction

	// breakpoint of negated lines (a1,b1),(a2,b2) with a1 <= a2
	function longint cross_x(longint a1, longint b1, longint a2, longint b2);
		if (a1 == a2)
			return (b1 >= b2) ? INF : -INF;
		return div_down(b1 - b2, a2 - a1);
	endfunction

	function logic [1:0] insert_line(longint s, longint b);
		longint na, nb, t, bp;
		int unsigned pops, k, sl;
		na = -s;
		nb = -b;
		if (count == 0 || na <= -longint'(slopes[slot(0)])) begin
			pops = 0;
			bp = INF;
			while (pops < count) begin
				sl = slot(pops);
				t = cross_x(na, nb, -longint'(slopes[sl]), -icpts[sl]);
				if (t >= bps[sl]) begin
					pops++;
				end else begin
					bp = t;
					break;
				end
			end
			if (count - pops + 1 > DEPTH)
				return ST_FULL;
			head = (head + pops + DEPTH - 1) % DEPTH;
			count = count - pops + 1;
			slopes[head] = int'(s);
			icpts[head] = b;
			bps[head] = bp;
			return ST_OK;
		end
		if (na < -longint'(slopes[slot(count - 1)]))
			return ST_ORDER;
		k = count - 1;
		forever begin
			sl = slot(k);
			t = cross_x(-longint'(slopes[sl]), -icpts[sl], na, nb);
			if (k > 0 && bps[slot(k - 1)] >= t)
				k--;
			else
				break;
		end
		if (k + 2 > DEPTH)
			return ST_FULL;
		bps[slot(k)] = t;
		sl = slot(k + 1);
		slopes[sl] = int'(s);
		icpts[sl] = b;
		bps[sl] = INF;
		count = k + 2;
		return ST_OK;
	endfunction

	// accepted input word: work out its result word
	function void note_word(logic o, logic signed [31:0] s, logic signed [47:0] b,
			logic signed [31:0] x);
		longint v;
		logic [1:0] st;
		int unsigned sl;
		v = 0;
		st = ST_OK;
		if (o == OP_ADD) begin
			st = insert_line(longint'(s), longint'(b));
		end else if (count == 0) begin
			st = ST_EMPTY;
		end else if (q_rising) begin
			while (count > 1 && bps[slot(0)] < longint'(x)) begin
				head = slot(1);
				count--;
			end
			sl = slot(0);
			v = longint'(slopes[sl]) * longint'(x) + icpts[sl];
		end else begin
			while (count > 1 && bps[slot(count - 2)] >= longint'(x))
				count--;
			sl = slot(count - 1);
			v = longint'(slopes[sl]) * longint'(x) + icpts[sl];
		end
		exp_value = {exp_value, v};
		exp_status = {exp_status, st};
	endfunction

	function void check_word(logic signed [63:0] v, logic [1:0] st);
		longint ev;
		logic [1:0] es;
		if (exp_status.size() == 0) begin
			$display("%0t: unexpected result word value=%0d status=%0d", $time, v, st);
			errors++;
			return;
		end
		ev = exp_value[0];
		es = exp_status[0];
		exp_value.delete(0);
		exp_status.delete(0);
		if (st !== es) begin
			$display("%0t: status expected %0d actual %0d", $time, es, st);
			errors++;
		end
		if (v !== ev) begin
			$display("%0t: min_value expected %0d actual %0d", $time, ev, v);
			errors++;
		end
	endfunction
endclass

module testbench;
	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic               op;
	logic signed [31:0] slope;
	logic signed [47:0] intercept;
	logic signed [31:0] query_point;
	logic               out_valid;
	logic               out_ready;
	logic signed [63:0] min_value;
	logic [1:0]         status;

	hull_scoreboard sb;
	bit     no_gaps;
	bit     hold_req;
	longint last_x;

	monotone_line_hull_min_query uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .slope(slope),
		.intercept(intercept), .query_point(query_point), .out_valid(out_valid),
		.out_ready(out_ready), .min_value(min_value), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	// offer one word and wait for it to be taken
	task send_word(logic o, longint s, longint b, longint x);
		in_valid <= 1'b1;
		op <= o;
		slope <= s[31:0];
		intercept <= b[47:0];
		query_point <= x[31:0];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_word(o, s[31:0], b[47:0], x[31:0]);
	endtask

	task idle_gap();
		int n;
		n = gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// register write with the block idle
	task write_order(bit rising);
		drain();
		repeat (60) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= rising;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.q_rising = rising;
	endtask

	function longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function longint rand_icpt();
		logic [63:0] r;
		r = {$urandom, $urandom};
		if ($urandom_range(0, 3) == 0)
			return longint'($signed(r[47:0]));
		return longint'($signed(r[23:0]));
	endfunction

	// one random word, mostly in slope and query order
	task random_word();
		int r;
		longint s, x;
		logic [63:0] w;
		r = $urandom_range(0, 99);
		w = {$urandom, $urandom};
		if (r < 50) begin
			if (sb.count == 0 || r < 4)
				s = longint'($signed(w[31:0]));
			else if (r < 27)
				s = clamp32(longint'(sb.front_slope()) + $urandom_range(0, 40000));
			else
				s = clamp32(longint'(sb.back_slope()) - $urandom_range(0, 40000));
			send_word(OP_ADD, s, rand_icpt(), longint'($signed(w[63:32])));
		end else begin
			if (r > 93)
				x = longint'($signed(w[31:0]));
			else if (sb.q_rising)
				x = clamp32(last_x + $urandom_range(0, 30000));
			else
				x = clamp32(last_x - $urandom_range(0, 30000));
			last_x = x;
			send_word(OP_QUERY, longint'($signed(w[63:32])), longint'($signed(w[47:0])), x);
		end
	endtask

	// result side: random back-pressure plus one long hold-off on request
	initial begin
		int n;
		out_ready = 1'b0;
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end
			n = gap_len();
			out_ready <= (n == 0);
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_word(min_value, status);
		end
	end

	initial begin
		int k;
		sb = new();
		no_gaps = 1'b0;
		hold_req = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_valid = 1'b0;
		op = OP_ADD;
		slope = '0;
		intercept = '0;
		query_point = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// query on an empty deque
		send_word(OP_QUERY, 0, 0, 5);
		idle_gap();

		// fill: tangents of a parabola, none made useless, then one too many
		no_gaps = 1'b1;
		for (k = 0; k < 1024; k++)
			send_word(OP_ADD, -k, longint'(k) * k, 0);
		send_word(OP_ADD, -1024, 1024 * 1024, 0);
		send_word(OP_ADD, 1, 100, 0);
		no_gaps = 1'b0;
		send_word(OP_QUERY, 0, 0, -64'sd2147483648);
		send_word(OP_QUERY, 0, 0, 1001);
		send_word(OP_QUERY, 0, 0, 2147483647);
		drain();

		// directed: extremes, ties, order error, both query orders
		write_order(1'b0);
		send_word(OP_ADD, -64'sd2147483648, -64'sd140737488355328, 0);
		send_word(OP_ADD, 2147483647, 64'sd140737488355327, 0);
		send_word(OP_ADD, 2147483647, -64'sd140737488355328, 0);
		send_word(OP_ADD, -64'sd2147483648, 64'sd140737488355327, 0);
		send_word(OP_ADD, 5, 7, 0);
		send_word(OP_ADD, 0, 0, 0);
		send_word(OP_QUERY, 0, 0, 2147483647);
		send_word(OP_QUERY, 0, 0, 1);
		send_word(OP_QUERY, 0, 0, -64'sd2147483648);
		send_word(OP_QUERY, 0, 0, 2147483647);
		write_order(1'b1);
		send_word(OP_ADD, -64'sd2147483648, 3, 0);
		send_word(OP_QUERY, 0, 0, -64'sd2147483648);
		send_word(OP_QUERY, 0, 0, 0);
		send_word(OP_QUERY, 0, 0, 2147483647);
		drain();

		// random phases, alternating query order
		for (k = 0; k < 8; k++) begin
			int j;
			write_order(k[0] == 1'b0);
			last_x = sb.q_rising ? -64'sd2000000 : 64'sd2000000;
			no_gaps = (k == 3);
			if (k == 2)
				hold_req = 1'b1;
			for (j = 0; j < 125; j++) begin
				random_word();
				idle_gap();
				if (k == 5 && j == 120)
					drain();
			end
		end
		no_gaps = 1'b0;

		drain();
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
